// File: rtl/hsbl_pkg.sv
// types and constants shared by the hsb lamp duty controller
`default_nettype none

package hsbl_pkg;

  // command and result payloads
  typedef struct packed {
    logic [2:0]  opcode;
    logic [15:0] value;
  } cmd_t;

  typedef struct packed {
    logic [13:0] red_duty;
    logic [13:0] green_duty;
    logic [13:0] blue_duty;
    logic        lamp_on;
    logic [1:0]  status;
  } result_t;

  typedef enum logic [2:0] {
    OP_POWER     = 3'd0,
    OP_FORCE_OFF = 3'd1,
    OP_SAT       = 3'd2,
    OP_HUE       = 3'd3,
    OP_BRIGHT    = 3'd4
  } opcode_t;

  typedef enum logic [1:0] {
    STAT_NONE     = 2'd0,
    STAT_UPDATED  = 2'd1,
    STAT_REJECTED = 2'd2
  } status_t;

  // sequencer states and recompute steps
  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_ISSUE,
    S_WAIT,
    S_DONE
  } state_t;

  typedef enum logic [2:0] {
    STEP_FS,
    STEP_P,
    STEP_Q,
    STEP_T,
    STEP_R,
    STEP_G,
    STEP_B
  } step_t;

  // divide mode of the shared multiply/divide unit
  typedef enum logic [1:0] {
    DIV_NONE,
    DIV_100,
    DIV_10K
  } div_t;

  localparam int MD_A_W      = 14;
  localparam int MD_B_W      = 17;
  localparam int MD_P_W      = 23;   // largest product is 100 * 65536
  localparam int MD_R_W      = 17;
  localparam int RECIP_W     = 24;
  localparam int RECIP_SHIFT = 30;

  // floor(2^30 / d), always at or below the true quotient
  localparam logic [RECIP_W-1:0] RECIP_100 = 24'd10737418;
  localparam logic [RECIP_W-1:0] RECIP_10K = 24'd107374;

  localparam logic [6:0]  PCT_FULL   = 7'd100;
  localparam logic [13:0] PCT_SQ     = 14'd10000;
  localparam logic [15:0] HUE_WRAP   = 16'd360;
  localparam logic [8:0]  SECTOR_DEG = 9'd60;

  // floor(5 * x / 3) for x below 60 as (x * 3415) >> 11
  localparam logic [17:0] FRAC_MUL   = 18'd3415;
  localparam int          FRAC_SHIFT = 11;

  typedef struct packed {
    logic              go;
    div_t              div;
    logic [MD_A_W-1:0] a;
    logic [MD_B_W-1:0] b;
  } md_req_t;

  typedef struct packed {
    logic              done;
    logic [MD_R_W-1:0] result;
  } md_rsp_t;

endpackage

`default_nettype wire

// File: rtl/hsbl_muldiv.sv
// shared three-stage multiply and divide-by-constant unit
`default_nettype none

module hsbl_muldiv (
  input  logic             clk,
  input  logic             rst,
  input  hsbl_pkg::md_req_t req,
  output hsbl_pkg::md_rsp_t rsp
);
  import hsbl_pkg::*;

  localparam int MQ_W = MD_P_W + RECIP_W;

  logic                v1, v2;
  div_t                div1, div2;
  logic [MD_P_W-1:0]   prod1, prod2;
  logic [MD_R_W-1:0]   q2;

  logic [31:0]         full;
  logic [RECIP_W-1:0]  recip;
  logic [MQ_W-1:0]     mq;
  logic [MD_R_W-1:0]   q0;
  logic [MD_A_W-1:0]   dcon;
  logic [31:0]         qd_full;
  logic [MD_P_W-1:0]   rem;
  logic [MD_R_W-1:0]   qfix;
  logic [MD_R_W-1:0]   result_c;

  // stage 1: operand product
  assign full = 32'(req.a) * 32'(req.b);

  // stage 2: reciprocal multiply, may fall one short
  assign recip = (div1 == DIV_10K) ? RECIP_10K : RECIP_100;
  assign mq    = MQ_W'(prod1) * MQ_W'(recip);
  assign q0    = mq[RECIP_SHIFT +: MD_R_W];

  // stage 3: one-step correction
  assign dcon    = (div2 == DIV_10K) ? PCT_SQ : MD_A_W'(PCT_FULL);
  assign qd_full = 32'(q2) * 32'(dcon);
  assign rem     = prod2 - qd_full[MD_P_W-1:0];
  assign qfix    = (rem >= MD_P_W'(dcon)) ? q2 + MD_R_W'(1) : q2;
  assign result_c = (div2 == DIV_NONE) ? prod2[MD_R_W-1:0] : qfix;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1       <= 1'b0;
      v2       <= 1'b0;
      rsp.done <= 1'b0;
    end else begin
      v1         <= req.go;
      v2         <= v1;
      rsp.done   <= v2;
      prod1      <= full[MD_P_W-1:0];
      div1       <= req.div;
      prod2      <= prod1;
      div2       <= div1;
      q2         <= q0;
      rsp.result <= result_c;
    end
  end

  a_latency: assert property (@(posedge clk) disable iff (rst)
    req.go |-> ##3 rsp.done)
    else $error("muldiv result missing three cycles after go");

  a_done_source: assert property (@(posedge clk) disable iff (rst)
    rsp.done |-> $past(req.go, 3))
    else $error("muldiv result without a matching go");

  a_single_op: assert property (@(posedge clk) disable iff (rst)
    $onehot0({v1, v2, rsp.done}))
    else $error("muldiv holds more than one operation");

endmodule

`default_nettype wire

// File: rtl/hsb_lamp_rgb_duty_controller_core.sv
// top level of the hsb lamp rgb duty controller
//
//  channel | direction | signals                        | content
//  --------+-----------+--------------------------------+------------------------------
//  cmd     | in        | cmd_valid, cmd_ready, cmd      | opcode, value
//  rsp     | out       | rsp_valid, rsp_ready, rsp      | r/g/b duty, lamp_on, status
//
// a command that recomputes goes through accept, range check, then seven
//   passes through the shared multiply/divide unit (issue plus three pipeline
//   stages), then the result load
// a command with no recompute, or one rejected out of range, skips the unit after the check
// reset (rst, synchronous) clears hue, saturation, brightness, saved brightness,
//   the on flag and the duties; the lamp starts off
// cmd_ready is high only while the sequencer is idle; a result waiting on rsp
//   does not block the next request, which stalls only at its own result load
`default_nettype none

module hsb_lamp_rgb_duty_controller_core #(
  parameter int DUTY_FULL = 8192
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cmd_valid,
  output logic             cmd_ready,
  input  hsbl_pkg::cmd_t    cmd,
  output logic             rsp_valid,
  input  logic             rsp_ready,
  output hsbl_pkg::result_t rsp
);
  import hsbl_pkg::*;

  // architectural state
  logic [15:0] hue_deg, sat_pct, bright_pct, saved_bright;
  logic        is_on;
  logic [13:0] duty_r, duty_g, duty_b;

  // sequencer
  state_t      state, state_next;
  step_t       step;
  logic        recomp_req;
  status_t     stat;

  // recompute working registers
  logic [2:0]  sector;
  logic [6:0]  frac;
  logic [13:0] fs;
  logic [6:0]  pct_p, pct_q, pct_t;

  // handshake decode
  logic        cmd_fire;
  logic        load_rsp;

  // range check and sector split
  logic        out_of_range;
  logic [8:0]  hue_eff;
  logic [2:0]  sector_c;
  logic [8:0]  sector_base;
  logic [5:0]  hmod;
  logic [17:0] frac_full;

  logic [6:0]  sat7, v7;
  logic [13:0] sat100;
  logic [6:0]  chan_pct;

  md_req_t     md_req;
  md_rsp_t     md_rsp;

  assign cmd_fire = cmd_valid && cmd_ready;
  assign sat7     = sat_pct[6:0];
  assign v7       = bright_pct[6:0];
  assign sat100   = 14'(sat7) * 14'(PCT_FULL);

  assign out_of_range = (hue_deg > HUE_WRAP) || (sat_pct > 16'(PCT_FULL)) ||
                        (bright_pct > 16'(PCT_FULL));

  // hue 360 folds onto 0
  assign hue_eff = (hue_deg == HUE_WRAP) ? 9'd0 : hue_deg[8:0];

  always_comb begin
    priority if (hue_eff >= 9'(5 * SECTOR_DEG)) begin
      sector_c    = 3'd5;
      sector_base = 9'(5 * SECTOR_DEG);
    end else if (hue_eff >= 9'(4 * SECTOR_DEG)) begin
      sector_c    = 3'd4;
      sector_base = 9'(4 * SECTOR_DEG);
    end else if (hue_eff >= 9'(3 * SECTOR_DEG)) begin
      sector_c    = 3'd3;
      sector_base = 9'(3 * SECTOR_DEG);
    end else if (hue_eff >= 9'(2 * SECTOR_DEG)) begin
      sector_c    = 3'd2;
      sector_base = 9'(2 * SECTOR_DEG);
    end else if (hue_eff >= SECTOR_DEG) begin
      sector_c    = 3'd1;
      sector_base = SECTOR_DEG;
    end else begin
      sector_c    = 3'd0;
      sector_base = 9'd0;
    end
  end

  // position inside the sector in percent, 0 to 98
  assign hmod      = 6'(hue_eff - sector_base);
  assign frac_full = (18'(hmod) * FRAC_MUL) >> FRAC_SHIFT;

  // six-sector channel pick: v, p, q or t
  always_comb begin
    chan_pct = v7;
    unique case (step)
      STEP_R: begin
        unique case (sector)
          3'd0, 3'd5: chan_pct = v7;
          3'd1:       chan_pct = pct_q;
          3'd2, 3'd3: chan_pct = pct_p;
          3'd4:       chan_pct = pct_t;
          default:    chan_pct = v7;
        endcase
      end
      STEP_G: begin
        unique case (sector)
          3'd0:       chan_pct = pct_t;
          3'd1, 3'd2: chan_pct = v7;
          3'd3:       chan_pct = pct_q;
          3'd4, 3'd5: chan_pct = pct_p;
          default:    chan_pct = v7;
        endcase
      end
      STEP_B: begin
        unique case (sector)
          3'd0, 3'd1: chan_pct = pct_p;
          3'd2:       chan_pct = pct_t;
          3'd3, 3'd4: chan_pct = v7;
          3'd5:       chan_pct = pct_q;
          default:    chan_pct = v7;
        endcase
      end
      default: chan_pct = v7;
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (cmd_valid) state_next = S_CHECK;
      S_CHECK: begin
        if (!recomp_req || out_of_range) state_next = S_DONE;
        else                             state_next = S_ISSUE;
      end
      S_ISSUE: state_next = S_WAIT;
      S_WAIT: begin
        if (md_rsp.done) state_next = (step == STEP_B) ? S_DONE : S_ISSUE;
      end
      S_DONE:  if (!rsp_valid || rsp_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // sequencer outputs and unit operands
  always_comb begin
    cmd_ready  = (state == S_IDLE);
    load_rsp   = (state == S_DONE) && (!rsp_valid || rsp_ready);
    md_req.go  = (state == S_ISSUE);
    md_req.div = DIV_NONE;
    md_req.a   = '0;
    md_req.b   = '0;
    unique case (step)
      STEP_FS: begin
        // frac * s, no divide
        md_req.a   = MD_A_W'(frac);
        md_req.b   = MD_B_W'(sat7);
        md_req.div = DIV_NONE;
      end
      STEP_P: begin
        md_req.a   = MD_A_W'(PCT_FULL - sat7);
        md_req.b   = MD_B_W'(v7);
        md_req.div = DIV_100;
      end
      STEP_Q: begin
        md_req.a   = PCT_SQ - fs;
        md_req.b   = MD_B_W'(v7);
        md_req.div = DIV_10K;
      end
      STEP_T: begin
        // 10000 - s * (100 - frac) rewritten without the product
        md_req.a   = PCT_SQ - sat100 + fs;
        md_req.b   = MD_B_W'(v7);
        md_req.div = DIV_10K;
      end
      STEP_R, STEP_G, STEP_B: begin
        md_req.a   = MD_A_W'(chan_pct);
        md_req.b   = MD_B_W'(DUTY_FULL);
        md_req.div = DIV_100;
      end
      default: begin
        md_req.div = DIV_NONE;
      end
    endcase
  end

  hsbl_muldiv u_muldiv (
    .clk (clk),
    .rst (rst),
    .req (md_req),
    .rsp (md_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      step         <= STEP_FS;
      recomp_req   <= 1'b0;
      stat         <= STAT_NONE;
      hue_deg      <= '0;
      sat_pct      <= '0;
      bright_pct   <= '0;
      saved_bright <= '0;
      is_on        <= 1'b0;
      duty_r       <= '0;
      duty_g       <= '0;
      duty_b       <= '0;
      rsp_valid    <= 1'b0;
    end else begin
      state <= state_next;

      // command decode updates the stored operands right away
      if (cmd_fire) begin
        unique case (cmd.opcode)
          OP_POWER: begin
            if (cmd.value[0]) begin
              bright_pct <= saved_bright;
              is_on      <= 1'b1;
            end else begin
              saved_bright <= bright_pct;
              bright_pct   <= '0;
              is_on        <= 1'b0;
            end
            recomp_req <= 1'b1;
          end
          OP_FORCE_OFF: begin
            bright_pct <= '0;
            is_on      <= 1'b0;
            recomp_req <= 1'b1;
          end
          OP_SAT: begin
            sat_pct    <= cmd.value;
            recomp_req <= is_on;
          end
          OP_HUE: begin
            hue_deg    <= cmd.value;
            recomp_req <= is_on;
          end
          OP_BRIGHT: begin
            bright_pct   <= cmd.value;
            saved_bright <= cmd.value;
            recomp_req   <= is_on;
          end
          default: recomp_req <= 1'b0;
        endcase
      end

      if (state == S_CHECK) begin
        sector <= sector_c;
        frac   <= frac_full[6:0];
        step   <= STEP_FS;
        if (!recomp_req)       stat <= STAT_NONE;
        else if (out_of_range) stat <= STAT_REJECTED;
        else                   stat <= STAT_UPDATED;
      end

      // collect each step's result and move on
      if (md_rsp.done) begin
        unique case (step)
          STEP_FS: fs     <= md_rsp.result[13:0];
          STEP_P:  pct_p  <= md_rsp.result[6:0];
          STEP_Q:  pct_q  <= md_rsp.result[6:0];
          STEP_T:  pct_t  <= md_rsp.result[6:0];
          STEP_R:  duty_r <= md_rsp.result[13:0];
          STEP_G:  duty_g <= md_rsp.result[13:0];
          STEP_B:  duty_b <= md_rsp.result[13:0];
          default: fs     <= fs;
        endcase
        if (step != STEP_B) step <= step_t'(step + 3'd1);
      end

      // output register, refilled when empty or when the previous result is taken
      if (load_rsp) begin
        rsp_valid      <= 1'b1;
        rsp.red_duty   <= duty_r;
        rsp.green_duty <= duty_g;
        rsp.blue_duty  <= duty_b;
        rsp.lamp_on    <= is_on;
        rsp.status     <= stat;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  a_check_after_accept: assert property (@(posedge clk) disable iff (rst)
    (state == S_CHECK) |-> $past(cmd_valid && cmd_ready))
    else $error("range check entered without an accepted request");

  a_done_while_waiting: assert property (@(posedge clk) disable iff (rst)
    md_rsp.done |-> (state == S_WAIT))
    else $error("unit result arrived outside the wait state");

  a_duty_hold: assert property (@(posedge clk) disable iff (rst)
    !md_rsp.done |=> $stable(duty_r) && $stable(duty_g) && $stable(duty_b))
    else $error("duty changed without a unit result");

  a_off_is_dark: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp.lamp_on && (rsp.status == STAT_UPDATED)) |->
      (rsp.red_duty == '0) && (rsp.green_duty == '0) && (rsp.blue_duty == '0))
    else $error("lamp off but duties updated to nonzero");

endmodule

`default_nettype wire

// File: tb/hsb_lamp_rgb_duty_controller_core_test.sv
// self-checking testbench for the hsb lamp rgb duty controller core
`default_nettype none

module hsb_lamp_rgb_duty_controller_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import hsbl_pkg::*;

  localparam int DUTY_FULL   = 8192;
  // about 670 requests with the worst gaps and stalls, plus the long hold, several times over
  localparam int CYCLE_LIMIT = 400000;
  // covers a full recompute, so anything still in flight would come out
  localparam int SETTLE_CYCLES = 80;
  localparam int HOLD_CYCLES   = 400;
  localparam int RANDOM_ITEMS  = 600;

  // opcodes the block does not decode
  localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
  localparam logic [2:0] OP_SPARE_MID   = 3'd6;
  localparam logic [2:0] OP_SPARE_LAST  = 3'd7;

  localparam logic [15:0] VALUE_ONES = 16'hFFFF;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    cmd_valid = 1'b0;
  logic    cmd_ready;
  cmd_t    cmd = '0;
  logic    rsp_valid;
  logic    rsp_ready = 1'b0;
  result_t rsp;

  hsb_lamp_rgb_duty_controller_core #(
    .DUTY_FULL(DUTY_FULL)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .cmd_valid(cmd_valid),
    .cmd_ready(cmd_ready),
    .cmd      (cmd),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp      (rsp)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // lamp state as the block should hold it
  // ---------------------------------------------------------------------------
  logic [15:0] hue_now, sat_now, bright_now, bright_saved;
  logic        lamp_is_on;
  logic [13:0] red_now, green_now, blue_now;

  // results still owed by the block, oldest first
  result_t lamp_results_due[$];

  int error_count = 0;
  int cycle_count = 0;

  // knobs the test tasks turn
  bit sender_gaps_on    = 1'b0;
  bit ready_stalls_on   = 1'b0;
  int ready_hold_left   = 0;
  int ready_stall_left  = 0;

  // percent to pwm count, floor, kept to the 14-bit register
  function automatic logic [13:0] pct_to_duty(input int unsigned pct);
    longint unsigned scaled;
    scaled = longint'(pct) * DUTY_FULL / 100;
    return scaled[13:0];
  endfunction

  // six-sector integer hsb to rgb, duties held when an operand is out of range
  function automatic status_t recompute_duties();
    int unsigned h, s, v, sector, frac, p, q, t, r, g, b;
    h = 32'(hue_now);
    s = 32'(sat_now);
    v = 32'(bright_now);
    if (h > 360 || s > 100 || v > 100) return STAT_REJECTED;
    // a full turn is the same color as zero degrees
    if (h == 360) h = 0;
    sector = (h / 60) % 6;
    frac   = (100 * h) / 60 - 100 * sector;
    p = v * (100 - s) / 100;
    q = v * (10000 - frac * s) / 10000;
    t = v * (10000 - s * (100 - frac)) / 10000;
    case (sector)
      0: begin r = v; g = t; b = p; end
      1: begin r = q; g = v; b = p; end
      2: begin r = p; g = v; b = t; end
      3: begin r = p; g = q; b = v; end
      4: begin r = t; g = p; b = v; end
      default: begin r = v; g = p; b = q; end
    endcase
    red_now   = pct_to_duty(r);
    green_now = pct_to_duty(g);
    blue_now  = pct_to_duty(b);
    return STAT_UPDATED;
  endfunction

  // apply one lamp command and return the result the block must send
  function automatic result_t predict_lamp(input cmd_t c);
    status_t st;
    result_t res;
    st = STAT_NONE;
    case (c.opcode)
      OP_POWER: begin
        if (c.value[0]) begin
          // switching on brings back the remembered brightness
          bright_now = bright_saved;
          lamp_is_on = 1'b1;
        end else begin
          bright_saved = bright_now;
          bright_now   = '0;
          lamp_is_on   = 1'b0;
        end
        st = recompute_duties();
      end
      OP_FORCE_OFF: begin
        // forced off keeps the remembered brightness untouched
        bright_now = '0;
        lamp_is_on = 1'b0;
        st = recompute_duties();
      end
      OP_SAT: begin
        sat_now = c.value;
        if (lamp_is_on) st = recompute_duties();
      end
      OP_HUE: begin
        hue_now = c.value;
        if (lamp_is_on) st = recompute_duties();
      end
      OP_BRIGHT: begin
        bright_now   = c.value;
        bright_saved = c.value;
        if (lamp_is_on) st = recompute_duties();
      end
      default: ;
    endcase
    res.red_duty   = red_now;
    res.green_duty = green_now;
    res.blue_duty  = blue_now;
    res.lamp_on    = lamp_is_on;
    res.status     = st;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // result checking
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("%0t ns mismatch on %s: got %0d, want %0d", $time, what, got, want);
    error_count++;
  endtask

  // every accepted result is compared with the oldest owed one
  always @(posedge clk) begin
    result_t want;
    if (!rst && rsp_valid && rsp_ready) begin
      if (lamp_results_due.size() == 0) begin
        report_mismatch("result with none owed (status)", 32'(rsp.status), 0);
      end else begin
        want = lamp_results_due.pop_front();
        if (rsp.red_duty !== want.red_duty)
          report_mismatch("red_duty", 32'(rsp.red_duty), 32'(want.red_duty));
        if (rsp.green_duty !== want.green_duty)
          report_mismatch("green_duty", 32'(rsp.green_duty), 32'(want.green_duty));
        if (rsp.blue_duty !== want.blue_duty)
          report_mismatch("blue_duty", 32'(rsp.blue_duty), 32'(want.blue_duty));
        if (rsp.lamp_on !== want.lamp_on)
          report_mismatch("lamp_on", 32'(rsp.lamp_on), 32'(want.lamp_on));
        if (rsp.status !== want.status)
          report_mismatch("status", 32'(rsp.status), 32'(want.status));
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t ns run limit reached", $time);
      $display("hsb_lamp_rgb_duty_controller_core_test: errors");
      $finish;
    end
  end

  // mostly no gap, often a short one, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // result side: a long hold when asked for, random stalls when enabled
  always @(negedge clk) begin
    if (ready_hold_left > 0) begin
      ready_hold_left--;
      rsp_ready = 1'b0;
    end else if (ready_stall_left > 0) begin
      ready_stall_left--;
      rsp_ready = 1'b0;
    end else if (ready_stalls_on && $urandom_range(0, 4) == 0) begin
      ready_stall_left = pick_gap();
      rsp_ready = (ready_stall_left == 0);
    end else begin
      rsp_ready = 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // request side
  // ---------------------------------------------------------------------------

  // offer one request from a falling edge, wait for the handshake, then idle for a random
  // gap when gaps are on; valid stays up across back-to-back requests
  task automatic send_cmd(input logic [2:0] op, input logic [15:0] val);
    int gap;
    cmd.opcode = op;
    cmd.value  = val;
    cmd_valid  = 1'b1;
    do @(posedge clk); while (!cmd_ready);
    lamp_results_due.push_back(predict_lamp(cmd));
    @(negedge clk);
    gap = sender_gaps_on ? pick_gap() : 0;
    if (gap > 0) begin
      cmd_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // sender goes quiet until every owed result has come back
  task automatic wait_for_drain();
    cmd_valid = 1'b0;
    while (lamp_results_due.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // percent operand, mostly legal with the edges of the range well hit
  function automatic logic [15:0] pick_pct();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return 16'($urandom_range(0, 100));
    if (r < 90) return 16'($urandom_range(100, 101));
    return 16'($urandom_range(0, 65535));
  endfunction

  // hue operand, mostly legal, with the wrap point and just past it
  function automatic logic [15:0] pick_hue();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return 16'($urandom_range(0, 360));
    if (r < 90) return 16'($urandom_range(359, 361));
    return 16'($urandom_range(0, 65535));
  endfunction

  // one random request, weighted toward color changes with the lamp on
  task automatic send_random_cmd();
    int r;
    logic [15:0] val;
    r = $urandom_range(0, 99);
    if (r < 14) begin
      val = 16'($urandom_range(0, 65535));
      // on more often than off so color changes mostly recompute
      val[0] = ($urandom_range(0, 9) < 7);
      send_cmd(OP_POWER, val);
    end else if (r < 19) begin
      send_cmd(OP_FORCE_OFF, 16'($urandom_range(0, 65535)));
    end else if (r < 42) begin
      send_cmd(OP_SAT, pick_pct());
    end else if (r < 67) begin
      send_cmd(OP_HUE, pick_hue());
    end else if (r < 94) begin
      send_cmd(OP_BRIGHT, pick_pct());
    end else begin
      send_cmd(3'($urandom_range(OP_SPARE_LAST, OP_SPARE_FIRST)),
               16'($urandom_range(0, 65535)));
    end
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // brightness memory across on, off and forced off
  task automatic test_power_memory();
    send_cmd(OP_BRIGHT, 16'd80);       // lamp off: stored, nothing recomputed
    send_cmd(OP_POWER, 16'd1);         // on restores 80, white at hue 0 sat 0
    send_cmd(OP_POWER, 16'hFFFE);      // only bit 0 counts: off
    send_cmd(OP_POWER, VALUE_ONES);    // on again with every bit set
    send_cmd(OP_FORCE_OFF, VALUE_ONES);
    send_cmd(OP_POWER, 16'd1);         // saved brightness survived forced off
  endtask

  // full saturation and brightness around every sector and the wrap
  task automatic test_color_wheel();
    send_cmd(OP_SAT, 16'd100);
    send_cmd(OP_BRIGHT, 16'd100);
    send_cmd(OP_HUE, 16'd60);
    send_cmd(OP_HUE, 16'd120);
    send_cmd(OP_HUE, 16'd180);
    send_cmd(OP_HUE, 16'd240);
    send_cmd(OP_HUE, 16'd300);
    send_cmd(OP_HUE, 16'd359);
    send_cmd(OP_HUE, 16'd360);         // same as zero degrees
    send_cmd(OP_SAT, 16'd0);
  endtask

  // out-of-range operands reject and keep the old duties
  task automatic test_out_of_range();
    send_cmd(OP_HUE, 16'd361);
    send_cmd(OP_HUE, VALUE_ONES);
    send_cmd(OP_HUE, 16'd0);
    send_cmd(OP_SAT, 16'd101);
    send_cmd(OP_SAT, 16'd100);
    send_cmd(OP_BRIGHT, VALUE_ONES);
    send_cmd(OP_FORCE_OFF, 16'd0);     // clears brightness so it recomputes again
  endtask

  // undecoded opcodes change nothing
  task automatic test_spare_opcodes();
    send_cmd(OP_SPARE_FIRST, VALUE_ONES);
    send_cmd(OP_SPARE_MID, 16'd1);
    send_cmd(OP_SPARE_LAST, 16'h5555);
  endtask

  // receiver holds off long while requests keep coming: the block fills and
  // stalls its request side
  task automatic test_result_backpressure();
    @(posedge clk);
    ready_hold_left = HOLD_CYCLES;
    @(negedge clk);
    sender_gaps_on = 1'b0;
    send_cmd(OP_POWER, 16'd1);
    send_cmd(OP_SAT, 16'd70);
    send_cmd(OP_BRIGHT, 16'd90);
    repeat (10) send_random_cmd();
  endtask

  // sender pauses until everything is back, then carries on
  task automatic test_drain_pause();
    sender_gaps_on  = 1'b1;
    ready_stalls_on = 1'b1;
    repeat (10) send_random_cmd();
    wait_for_drain();
    repeat (10) send_random_cmd();
  endtask

  // random sequences in blocks, idling switched on and off per block
  task automatic test_random_sequences(input int count);
    for (int i = 0; i < count; i++) begin
      if (i % 50 == 0) begin
        sender_gaps_on  = ($urandom_range(0, 3) != 0);
        ready_stalls_on = ($urandom_range(0, 3) != 0);
        // a block usually starts by switching the lamp on
        if ($urandom_range(0, 3) != 0) send_cmd(OP_POWER, 16'd1);
      end
      send_random_cmd();
    end
  endtask

  initial begin
    hue_now      = '0;
    sat_now      = '0;
    bright_now   = '0;
    bright_saved = '0;
    lamp_is_on   = 1'b0;
    red_now      = '0;
    green_now    = '0;
    blue_now     = '0;

    repeat (10) @(negedge clk);
    rst = 1'b0;

    test_power_memory();
    test_color_wheel();
    test_out_of_range();
    test_spare_opcodes();
    test_result_backpressure();
    test_drain_pause();
    test_random_sequences(RANDOM_ITEMS);

    wait_for_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("hsb_lamp_rgb_duty_controller_core_test: clean");
    end else begin
      $display("hsb_lamp_rgb_duty_controller_core_test: errors");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: files.f
rtl/hsbl_pkg.sv
rtl/hsbl_muldiv.sv
rtl/hsb_lamp_rgb_duty_controller_core.sv
tb/hsb_lamp_rgb_duty_controller_core_test.sv
